### design/nfc_spi_command_monitor_core_macros.svh
// Assertion macros used by the monitor's checker file.
`ifndef NFC_SPI_COMMAND_MONITOR_CORE_MACROS_SVH
`define NFC_SPI_COMMAND_MONITOR_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define NSCM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define NSCM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/nscm_pkg.sv
// Shared types, codes and constants of the NFC SPI command monitor.
package nscm_pkg;

  // Longest data burst counted before bytes are flagged as excess
  localparam int MAX_BURST = 1024;
  localparam int CNT_W     = $clog2(MAX_BURST + 1);
  localparam int IDX_W     = 11;

  // Decoupling queue geometry
  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  // Record kinds
  localparam logic [2:0] REC_DATA    = 3'd0;
  localparam logic [2:0] REC_DIRECT  = 3'd1;
  localparam logic [2:0] REC_END     = 3'd2;
  localparam logic [2:0] REC_UNKNOWN = 3'd3;
  localparam logic [2:0] REC_MISSING = 3'd4;
  localparam logic [2:0] REC_EXCESS  = 3'd5;

  // Command kinds, plus internal pending codes
  localparam logic [3:0] KIND_WRITE   = 4'd0;
  localparam logic [3:0] KIND_READ    = 4'd1;
  localparam logic [3:0] KIND_WRITE_B = 4'd2;
  localparam logic [3:0] KIND_WRITE_T = 4'd4;
  localparam logic [3:0] KIND_FIFO_W  = 4'd6;
  localparam logic [3:0] KIND_FIFO_R  = 4'd7;
  localparam logic [3:0] KIND_DIRECT  = 4'd8;
  localparam logic [3:0] KIND_NONE    = 4'd9;
  localparam logic [3:0] KIND_PFX_B   = 4'd10;
  localparam logic [3:0] KIND_PFX_T   = 4'd11;

  // Chip-select event classes
  localparam logic [1:0] EV_NONE    = 2'd0;
  localparam logic [1:0] EV_RELEASE = 2'd1;
  localparam logic [1:0] EV_END     = 2'd2;

  // Chip-select level codes
  localparam logic [1:0] CS_LOW  = 2'd0;
  localparam logic [1:0] CS_HIGH = 2'd1;

  // Command byte classes
  localparam logic [3:0] CLS_REG_W   = 4'd0;
  localparam logic [3:0] CLS_REG_R   = 4'd1;
  localparam logic [3:0] CLS_FIFO_W  = 4'd2;
  localparam logic [3:0] CLS_SPEC_W  = 4'd3;
  localparam logic [3:0] CLS_SPEC_R  = 4'd4;
  localparam logic [3:0] CLS_FIFO_R  = 4'd5;
  localparam logic [3:0] CLS_DIRECT  = 4'd6;
  localparam logic [3:0] CLS_PFX_B   = 4'd7;
  localparam logic [3:0] CLS_PFX_T   = 4'd8;
  localparam logic [3:0] CLS_BAD     = 4'd9;

  // Command byte values
  localparam logic [7:0] ADDR_MASK    = 8'h3F;
  localparam logic [7:0] TOP_MASK     = 8'hC0;
  localparam logic [7:0] TOP_READ     = 8'h40;
  localparam logic [7:0] BYTE_FIFO_W  = 8'h80;
  localparam logic [7:0] BYTE_FIFO_R  = 8'h9F;
  localparam logic [7:0] BYTE_SPEC_W0 = 8'hA0;
  localparam logic [7:0] BYTE_SPEC_W1 = 8'hA8;
  localparam logic [7:0] BYTE_SPEC_W2 = 8'hAC;
  localparam logic [7:0] BYTE_SPEC_R  = 8'hBF;
  localparam logic [7:0] BYTE_DIR_LO  = 8'hC0;
  localparam logic [7:0] BYTE_DIR_HI  = 8'hE8;
  localparam logic [7:0] BYTE_PFX_B   = 8'hFB;
  localparam logic [7:0] BYTE_PFX_T   = 8'hFC;

  // Classified input word carried through the queue
  typedef struct packed {
    logic       is_cs;
    logic [1:0] ev;
    logic [3:0] cls;
    logic [7:0] mosi;
    logic [7:0] miso;
  } item_t;

  // One result record
  typedef struct packed {
    logic [2:0]       rec;
    logic [3:0]       kind;
    logic [7:0]       addr;
    logic [7:0]       data;
    logic [IDX_W-1:0] idx;
  } rec_t;

  // Queue to back-end handshake
  typedef struct packed {
    logic  valid;
    item_t item;
  } q_head_t;

endpackage

### design/nscm_front.sv
// Front end: classify chip-select events and command bytes of each input word.
module nscm_front (
  input  logic           in_mode,
  input  logic [7:0]     in_mosi,
  input  logic [7:0]     in_miso,
  input  logic [1:0]     in_cs_before,
  input  logic [1:0]     in_cs_after,
  output nscm_pkg::item_t item
);
  import nscm_pkg::*;

  logic [1:0] ev;
  logic [3:0] cls;

  // Classify chip-select change
  always_comb begin
    ev = EV_NONE;
    if (in_cs_after == CS_HIGH) begin
      if (in_cs_before[1]) begin
        ev = EV_RELEASE;
      end else if (in_cs_before == CS_LOW) begin
        ev = EV_END;
      end
    end
  end

  // Classify the MOSI byte as a command
  always_comb begin
    if ((in_mosi & TOP_MASK) == 8'h00) begin
      cls = CLS_REG_W;
    end else if ((in_mosi & TOP_MASK) == TOP_READ) begin
      cls = CLS_REG_R;
    end else if (in_mosi == BYTE_FIFO_W) begin
      cls = CLS_FIFO_W;
    end else if (in_mosi == BYTE_SPEC_W0 || in_mosi == BYTE_SPEC_W1 ||
                 in_mosi == BYTE_SPEC_W2) begin
      cls = CLS_SPEC_W;
    end else if (in_mosi == BYTE_SPEC_R) begin
      cls = CLS_SPEC_R;
    end else if (in_mosi == BYTE_FIFO_R) begin
      cls = CLS_FIFO_R;
    end else if (in_mosi >= BYTE_DIR_LO && in_mosi <= BYTE_DIR_HI) begin
      cls = CLS_DIRECT;
    end else if (in_mosi == BYTE_PFX_B) begin
      cls = CLS_PFX_B;
    end else if (in_mosi == BYTE_PFX_T) begin
      cls = CLS_PFX_T;
    end else begin
      cls = CLS_BAD;
    end
  end

  assign item.is_cs = in_mode;
  assign item.ev    = ev;
  assign item.cls   = cls;
  assign item.mosi  = in_mosi;
  assign item.miso  = in_miso;

endmodule

### design/nscm_queue.sv
// Short queue between the classifying front end and the executing back end.
module nscm_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  nscm_pkg::item_t   push_item,
  output logic              can_push,
  input  logic              pop,
  output nscm_pkg::q_head_t head
);
  import nscm_pkg::*;

  item_t           slot_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CW-1:0] count_r, count_nxt;
  logic            do_push, do_pop;

  assign can_push = (count_r != Q_CW'(Q_DEPTH));
  assign do_push  = push && can_push;
  assign do_pop   = pop && (count_r != '0);

  assign head.valid = (count_r != '0);
  assign head.item  = slot_r[rd_ptr_r];

  // Advance pointers and fill level
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the pushed word
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

### design/nscm_back.sv
// Back end: transaction state, record generation and the output register.
module nscm_back (
  input  logic              clk,
  input  logic              rst_n,
  input  nscm_pkg::q_head_t head,
  output logic              pop,
  output logic              rec_valid,
  input  logic              rec_ready,
  output nscm_pkg::rec_t    rec
);
  import nscm_pkg::*;

  logic             expect_r, expect_nxt;
  logic [3:0]       pend_r, pend_nxt;
  logic [7:0]       addr_r, addr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             rel_r, rel_nxt;
  logic             out_valid_r, out_valid_nxt;
  rec_t             out_r, out_nxt;

  logic             emit;
  rec_t             new_rec;
  logic             prefixed;
  logic [3:0]       base;
  logic [7:0]       b;
  logic [7:0]       low_addr;
  item_t            it;

  assign it        = head.item;
  assign b         = it.mosi;
  assign low_addr  = b & ADDR_MASK;
  assign prefixed  = (pend_r == KIND_PFX_B) || (pend_r == KIND_PFX_T);
  assign base      = (pend_r == KIND_PFX_B) ? KIND_WRITE_B : KIND_WRITE_T;

  // Take a word whenever the output register is free or being drained
  assign pop = head.valid && (!out_valid_r || rec_ready);

  // Execute one word against the transaction state
  always_comb begin
    expect_nxt = expect_r;
    pend_nxt   = pend_r;
    addr_nxt   = addr_r;
    cnt_nxt    = cnt_r;
    rel_nxt    = rel_r;
    emit       = 1'b0;
    new_rec    = '0;
    new_rec.addr = b;

    if (it.is_cs) begin
      if (it.ev == EV_RELEASE) begin
        rel_nxt = 1'b1;
      end else if (it.ev == EV_END) begin
        if (pend_r < KIND_DIRECT) begin
          emit         = 1'b1;
          new_rec.rec  = (cnt_r == '0) ? REC_MISSING : REC_END;
          new_rec.kind = pend_r;
          new_rec.addr = addr_r;
          new_rec.idx  = IDX_W'(cnt_r);
        end
        expect_nxt = 1'b1;
        pend_nxt   = KIND_NONE;
        addr_nxt   = '0;
        cnt_nxt    = '0;
        rel_nxt    = 1'b1;
      end
    end else if (rel_r && expect_r && prefixed) begin
      // Second byte after a space prefix
      if (it.cls == CLS_PFX_B || it.cls == CLS_PFX_T) begin
        emit        = 1'b1;
        new_rec.rec = REC_UNKNOWN;
      end else if (it.cls == CLS_REG_W || it.cls == CLS_REG_R) begin
        pend_nxt   = (it.cls == CLS_REG_R) ? (base | 4'd1) : base;
        addr_nxt   = low_addr;
        cnt_nxt    = '0;
        expect_nxt = 1'b0;
      end else begin
        emit        = 1'b1;
        new_rec.rec = REC_UNKNOWN;
        expect_nxt  = 1'b1;
        pend_nxt    = KIND_NONE;
        addr_nxt    = '0;
        cnt_nxt     = '0;
      end
    end else if (rel_r && expect_r) begin
      // Plain command byte
      unique case (it.cls)
        CLS_REG_W, CLS_REG_R, CLS_FIFO_W, CLS_SPEC_W, CLS_SPEC_R, CLS_FIFO_R: begin
          expect_nxt = 1'b0;
          cnt_nxt    = '0;
          addr_nxt   = b;
          case (it.cls)
            CLS_REG_W: begin
              pend_nxt = KIND_WRITE;
              addr_nxt = low_addr;
            end
            CLS_REG_R: begin
              pend_nxt = KIND_READ;
              addr_nxt = low_addr;
            end
            CLS_FIFO_W: pend_nxt = KIND_FIFO_W;
            CLS_SPEC_W: pend_nxt = KIND_WRITE;
            CLS_SPEC_R: pend_nxt = KIND_READ;
            default:    pend_nxt = KIND_FIFO_R;
          endcase
        end
        CLS_DIRECT: begin
          emit         = 1'b1;
          new_rec.rec  = REC_DIRECT;
          new_rec.kind = KIND_DIRECT;
          expect_nxt   = 1'b1;
          pend_nxt     = KIND_NONE;
          addr_nxt     = '0;
          cnt_nxt      = '0;
        end
        CLS_PFX_B: pend_nxt = KIND_PFX_B;
        CLS_PFX_T: pend_nxt = KIND_PFX_T;
        default: begin
          emit        = 1'b1;
          new_rec.rec = REC_UNKNOWN;
          expect_nxt  = 1'b1;
          pend_nxt    = KIND_NONE;
          addr_nxt    = '0;
          cnt_nxt     = '0;
        end
      endcase
    end else if (rel_r) begin
      // Data byte of an open burst
      emit         = 1'b1;
      new_rec.addr = addr_r;
      new_rec.idx  = IDX_W'(cnt_r);
      if (pend_r >= KIND_DIRECT) begin
        new_rec.rec  = REC_EXCESS;
        new_rec.kind = KIND_WRITE;
      end else if (cnt_r >= CNT_W'(MAX_BURST)) begin
        new_rec.rec  = REC_EXCESS;
        new_rec.kind = pend_r;
      end else begin
        new_rec.rec  = REC_DATA;
        new_rec.kind = pend_r;
        new_rec.data = pend_r[0] ? it.miso : it.mosi;
        cnt_nxt      = cnt_r + 1'b1;
      end
    end
  end

  // Load or drain the output register
  always_comb begin
    out_valid_nxt = out_valid_r && !rec_ready;
    out_nxt       = out_r;
    if (pop && emit) begin
      out_valid_nxt = 1'b1;
      out_nxt       = new_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expect_r    <= 1'b1;
      pend_r      <= KIND_NONE;
      addr_r      <= '0;
      cnt_r       <= '0;
      rel_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        expect_r <= expect_nxt;
        pend_r   <= pend_nxt;
        addr_r   <= addr_nxt;
        cnt_r    <= cnt_nxt;
        rel_r    <= rel_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign rec_valid = out_valid_r;
  assign rec       = out_r;

endmodule

### design/nfc_spi_command_monitor_core.sv
// Top level of the NFC SPI command monitor: front end, queue and back end.
//
//  channel  | direction | tdata / tuser contents
//  ---------+-----------+-----------------------------------------------------
//  in_*     | input     | mosi, miso, cs_before, cs_after / mode
//  out_*    | output    | command_kind, reg_address, data_byte, byte_index /
//           |           | record_kind
//
// One word per cycle sustained while the output is not stalled; a word's record is
// loaded into the output register from its queue slot by the back-end update.
// The two-entry queue lets the front end keep taking words while a record
// waits in the output register; in_tready drops only when the queue is full.
// rst_n is synchronous: it returns to expecting a command with chip select
// not yet seen released, and empties the queue and output register.
module nfc_spi_command_monitor_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [7:0] mosi_byte, [15:8] miso_byte,
                                  // [17:16] cs_before, [19:18] cs_after, [23:20] 0
  input  logic [0:0]  in_tuser,   // [0] mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [3:0] command_kind, [11:4] reg_address,
                                  // [19:12] data_byte, [30:20] byte_index, [31] 0
  output logic [2:0]  out_tuser   // [2:0] record_kind
);
  import nscm_pkg::*;

  item_t   front_item;
  q_head_t head;
  logic    pop;
  rec_t    rec;

  // Classify the incoming word
  nscm_front u_front (
    .in_mode      (in_tuser[0]),
    .in_mosi      (in_tdata[7:0]),
    .in_miso      (in_tdata[15:8]),
    .in_cs_before (in_tdata[17:16]),
    .in_cs_after  (in_tdata[19:18]),
    .item         (front_item)
  );

  // Decouple front and back
  nscm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_tvalid),
    .push_item (front_item),
    .can_push  (in_tready),
    .pop       (pop),
    .head      (head)
  );

  // Execute and report
  nscm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .pop       (pop),
    .rec_valid (out_tvalid),
    .rec_ready (out_tready),
    .rec       (rec)
  );

  assign out_tdata = {1'b0, rec.idx, rec.data, rec.addr, rec.kind};
  assign out_tuser = rec.rec;

endmodule

### design/nscm_checker.sv
// Port-level checker for the NFC SPI command monitor, bound to the top level.
`include "nfc_spi_command_monitor_core_macros.svh"

module nscm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [2:0]  out_tuser
);
  import nscm_pkg::*;

  // A stalled record holds
  `NSCM_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled record changed")

  // Only data records carry a data byte
  `NSCM_ASSERT_IMP(a_data_only, out_tvalid && (out_tuser != REC_DATA), out_tdata[19:12] == 8'h00, "non-data record with data byte")

  // Direct commands always report the direct kind at index zero
  `NSCM_ASSERT_IMP(a_direct, out_tvalid && (out_tuser == REC_DIRECT), (out_tdata[3:0] == KIND_DIRECT) && (out_tdata[30:20] == '0), "bad direct record")

  // Burst positions never pass the burst limit
  `NSCM_ASSERT_IMP(a_idx_range, out_tvalid, out_tdata[30:20] <= IDX_W'(MAX_BURST), "byte index beyond burst limit")

endmodule

bind nfc_spi_command_monitor_core nscm_checker u_nscm_checker (.*);

### bench/tb_nfc_spi_command_monitor_core.sv
`timescale 1ns / 100ps
// Self-checking bench for the NFC SPI command monitor: stream traffic, protocol tracker, scoreboard.
module tb_nfc_spi_command_monitor_core;
  import nscm_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_SLACK  = 8;
  localparam int MAX_GAP      = 17;
  localparam int RANDOM_WORDS = 240;
  localparam int PRINT_CAP    = 40;
  localparam int RX_HOLD_LONG = 300;

  // Chip-select level codes beyond low and high; both mean unknown or no pin
  localparam logic [1:0] CS_NONE  = 2'd2;
  localparam logic [1:0] CS_CODE3 = 2'd3;

  localparam logic MODE_BYTE = 1'b0;
  localparam logic MODE_CS   = 1'b1;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;   // [7:0] mosi, [15:8] miso, [17:16] cs before, [19:18] cs after
  logic [0:0]  in_tuser;   // [0] mode
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // [3:0] command kind, [11:4] address, [19:12] data, [30:20] index
  logic [2:0]  out_tuser;  // [2:0] record kind

  // Protocol tracker state
  bit          wait_cmd      = 1'b1;
  logic [3:0]  pend_kind     = KIND_NONE;
  logic [7:0]  held_addr     = 8'h00;
  int unsigned burst_count   = 0;
  bit          cs_released   = 1'b0;

  rec_t        records_due[$];
  int          mismatches    = 0;
  int          words_sent    = 0;
  int          cycle_count   = 0;
  bit          tx_steady     = 1'b0;
  bit          rx_steady     = 1'b0;
  int          rx_hold_cycles = 0;

  nfc_spi_command_monitor_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic int draw_gap(bit steady);
    return steady ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  // Queue one predicted record
  function automatic void due_record(logic [2:0] rec, logic [3:0] kind, logic [7:0] addr,
                                     logic [7:0] data, int unsigned idx);
    rec_t r;
    r.rec  = rec;
    r.kind = kind;
    r.addr = addr;
    r.data = data;
    r.idx  = idx[IDX_W-1:0];
    records_due.push_back(r);
  endfunction

  function automatic void go_idle();
    wait_cmd    = 1'b1;
    pend_kind   = KIND_NONE;
    held_addr   = 8'h00;
    burst_count = 0;
  endfunction

  function automatic void open_burst(logic [3:0] kind, logic [7:0] addr);
    pend_kind   = kind;
    held_addr   = addr;
    burst_count = 0;
    wait_cmd    = 1'b0;
  endfunction

  // Classify a command byte, prefix handling first
  function automatic void track_command(logic [7:0] b);
    logic [7:0] top;
    logic [7:0] addr;
    logic [3:0] base;
    top  = b & TOP_MASK;
    addr = b & ADDR_MASK;
    if (pend_kind == KIND_PFX_B || pend_kind == KIND_PFX_T) begin
      base = (pend_kind == KIND_PFX_B) ? KIND_WRITE_B : KIND_WRITE_T;
      if (b == BYTE_PFX_B || b == BYTE_PFX_T) begin
        // repeated prefix: warn, keep the prefix pending
        due_record(REC_UNKNOWN, KIND_WRITE, b, 8'h00, 0);
      end else if (top == 8'h00) begin
        open_burst(base, addr);
      end else if (top == TOP_READ) begin
        open_burst(base | 4'd1, addr);
      end else begin
        due_record(REC_UNKNOWN, KIND_WRITE, b, 8'h00, 0);
        go_idle();
      end
    end else if (!b[7]) begin
      open_burst((top == 8'h00) ? KIND_WRITE : KIND_READ, addr);
    end else if (b == BYTE_FIFO_W) begin
      open_burst(KIND_FIFO_W, b);
    end else if (b == BYTE_SPEC_W0 || b == BYTE_SPEC_W1 || b == BYTE_SPEC_W2) begin
      open_burst(KIND_WRITE, b);
    end else if (b == BYTE_SPEC_R) begin
      open_burst(KIND_READ, b);
    end else if (b == BYTE_FIFO_R) begin
      open_burst(KIND_FIFO_R, b);
    end else if (b >= BYTE_DIR_LO && b <= BYTE_DIR_HI) begin
      due_record(REC_DIRECT, KIND_DIRECT, b, 8'h00, 0);
      go_idle();
    end else if (b == BYTE_PFX_B) begin
      pend_kind = KIND_PFX_B;
    end else if (b == BYTE_PFX_T) begin
      pend_kind = KIND_PFX_T;
    end else begin
      due_record(REC_UNKNOWN, KIND_WRITE, b, 8'h00, 0);
      go_idle();
    end
  endfunction

  // Advance the tracker by one accepted word
  function automatic void track_word(logic mode, logic [7:0] mosi, logic [7:0] miso,
                                     logic [1:0] cs_pre, logic [1:0] cs_post);
    if (mode == MODE_CS) begin
      if (cs_pre >= CS_NONE && cs_post == CS_HIGH) begin
        cs_released = 1'b1;
      end else if (cs_pre == CS_LOW && cs_post == CS_HIGH) begin
        if (pend_kind < KIND_DIRECT) begin
          if (burst_count == 0)
            due_record(REC_MISSING, pend_kind, held_addr, 8'h00, 0);
          else
            due_record(REC_END, pend_kind, held_addr, 8'h00, burst_count);
        end
        go_idle();
        cs_released = 1'b1;
      end
    end else if (cs_released) begin
      if (wait_cmd) begin
        track_command(mosi);
      end else if (pend_kind >= KIND_DIRECT) begin
        due_record(REC_EXCESS, KIND_WRITE, held_addr, 8'h00, burst_count);
      end else if (burst_count >= MAX_BURST) begin
        due_record(REC_EXCESS, pend_kind, held_addr, 8'h00, burst_count);
      end else begin
        due_record(REC_DATA, pend_kind, held_addr, pend_kind[0] ? miso : mosi, burst_count);
        burst_count++;
      end
    end
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    mismatches++;
    if (mismatches <= PRINT_CAP)
      $display("%0t: %s got %0d want %0d", $time, what, got, want);
  endtask

  // Offer one word after a random gap; hold it until taken
  task automatic send_word(logic mode, logic [7:0] mosi, logic [7:0] miso,
                           logic [1:0] cs_pre, logic [1:0] cs_post);
    int gap;
    gap = draw_gap(tx_steady);
    repeat (gap) @(negedge clk);
    in_tdata  = {4'd0, cs_post, cs_pre, miso, mosi};
    in_tuser  = mode;
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    track_word(mode, mosi, miso, cs_pre, cs_post);
    words_sent++;
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic send_byte(logic [7:0] mosi, logic [7:0] miso);
    send_word(MODE_BYTE, mosi, miso, CS_LOW, CS_LOW);
  endtask

  task automatic send_data(int count);
    repeat (count) send_byte(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
  endtask

  task automatic open_frame();
    send_word(MODE_CS, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
              CS_HIGH, CS_LOW);
  endtask

  task automatic close_frame();
    send_word(MODE_CS, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
              CS_LOW, CS_HIGH);
  endtask

  // Hold the sender until every predicted record has arrived
  task automatic wait_drain();
    while (records_due.size() != 0) @(negedge clk);
    repeat (DRAIN_SLACK) @(negedge clk);
  endtask

  function automatic logic [7:0] pick_command();
    logic [7:0] b;
    case ($urandom_range(0, 9))
      0, 1, 2: b = 8'($urandom_range(0, 127));
      3:       b = BYTE_FIFO_W;
      4:       b = BYTE_FIFO_R;
      5: begin
        case ($urandom_range(0, 3))
          0:       b = BYTE_SPEC_W0;
          1:       b = BYTE_SPEC_W1;
          2:       b = BYTE_SPEC_W2;
          default: b = BYTE_SPEC_R;
        endcase
      end
      6:       b = 8'($urandom_range(BYTE_DIR_LO, BYTE_DIR_HI));
      7:       b = 8'($urandom_range(0, 255));
      8:       b = 8'($urandom_range(BYTE_DIR_HI + 1, 255));
      default: b = 8'($urandom_range(BYTE_FIFO_W + 1, BYTE_FIFO_R - 1));
    endcase
    return b;
  endfunction

  // Bytes and stray edges before chip select is seen released
  task automatic test_before_release();
    send_byte(8'h00, 8'hFF);
    send_byte(8'hFF, 8'h00);
    send_byte(BYTE_DIR_LO, 8'hA5);
    send_word(MODE_CS, 8'h00, 8'h00, CS_LOW, CS_LOW);
    send_word(MODE_CS, 8'h00, 8'h00, CS_HIGH, CS_HIGH);
    send_word(MODE_CS, 8'h00, 8'h00, CS_CODE3, CS_LOW);
    send_byte(8'h00, 8'h00);
    send_word(MODE_CS, 8'hFF, 8'hFF, CS_NONE, CS_HIGH);
    wait_drain();
  endtask

  // Plain register writes and reads, field extremes, missing data
  task automatic test_register_access();
    open_frame();
    send_byte(8'h00, 8'h00);
    send_byte(8'hFF, 8'h00);
    send_byte(8'h00, 8'hFF);
    close_frame();
    open_frame();
    send_byte(8'h7F, 8'h00);
    send_byte(8'h00, 8'hFF);
    send_byte(8'hFF, 8'h00);
    close_frame();
    open_frame();
    send_byte(8'h40, 8'h00);
    close_frame();
    send_word(MODE_CS, 8'h00, 8'h00, CS_CODE3, CS_HIGH);
    send_word(MODE_CS, 8'h00, 8'h00, CS_HIGH, CS_NONE);
    wait_drain();
  endtask

  // FIFO, special-address, direct and unknown commands
  task automatic test_special_commands();
    logic [7:0] cmds[6];
    cmds = '{BYTE_FIFO_W, BYTE_FIFO_R, BYTE_SPEC_W0, BYTE_SPEC_W1, BYTE_SPEC_W2, BYTE_SPEC_R};
    foreach (cmds[i]) begin
      open_frame();
      send_byte(cmds[i], 8'($urandom_range(0, 255)));
      send_data(2);
      close_frame();
    end
    open_frame();
    send_byte(BYTE_DIR_LO, 8'h00);
    send_byte(BYTE_DIR_HI, 8'h00);
    send_byte(8'hD5, 8'h00);
    send_byte(8'h81, 8'h00);
    send_byte(BYTE_DIR_HI + 8'd1, 8'h00);
    send_byte(8'hFF, 8'h00);
    send_byte(8'hFD, 8'h00);
    send_byte(BYTE_SPEC_R - 8'd1, 8'h00);
    close_frame();
    wait_drain();
  endtask

  // Space-B and test prefixes, repeated prefix, bad command after prefix
  task automatic test_prefixes();
    open_frame();
    send_byte(BYTE_PFX_B, 8'h00);
    send_byte(8'h05, 8'h00);
    send_data(2);
    close_frame();
    open_frame();
    send_byte(BYTE_PFX_T, 8'h00);
    send_byte(8'h45, 8'h00);
    send_data(2);
    close_frame();
    open_frame();
    send_byte(BYTE_PFX_B, 8'h00);
    send_byte(BYTE_PFX_B, 8'h00);
    send_byte(BYTE_PFX_T, 8'h00);
    send_byte(8'h7F, 8'h00);
    send_data(1);
    close_frame();
    open_frame();
    send_byte(BYTE_PFX_T, 8'h00);
    send_byte(8'hC3, 8'h00);
    send_byte(8'h12, 8'h00);
    close_frame();
    open_frame();
    send_byte(BYTE_PFX_B, 8'h00);
    close_frame();
    open_frame();
    send_byte(BYTE_PFX_T, 8'h00);
    send_byte(8'h00, 8'h00);
    close_frame();
    wait_drain();
  endtask

  // Run a burst past the byte limit without idling
  task automatic test_excess_bytes();
    tx_steady = 1'b1;
    rx_steady = 1'b1;
    open_frame();
    send_byte(8'h21, 8'h00);
    send_data(MAX_BURST + 3);
    close_frame();
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    wait_drain();
  endtask

  // Stall the receiver long enough to back up the input
  task automatic test_backpressure();
    rx_hold_cycles = RX_HOLD_LONG;
    tx_steady = 1'b1;
    open_frame();
    send_byte(BYTE_SPEC_R, 8'h00);
    send_data(40);
    close_frame();
    tx_steady = 1'b0;
    wait_drain();
  endtask

  // Mostly well-formed frames with random content, some noise and broken frames
  task automatic test_random_traffic(int words);
    int stop_at;
    int pick;
    int count;
    stop_at = words_sent + words;
    while (words_sent < stop_at) begin
      if ($urandom_range(0, 7) == 0) tx_steady = ~tx_steady;
      if ($urandom_range(0, 7) == 0) rx_steady = ~rx_steady;
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        send_word(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)),
                  2'($urandom_range(0, 3)));
      end else begin
        if (pick >= 12) open_frame();
        if ($urandom_range(0, 4) == 0) begin
          send_byte($urandom_range(0, 1) ? BYTE_PFX_B : BYTE_PFX_T,
                    8'($urandom_range(0, 255)));
          if ($urandom_range(0, 3) == 0)
            send_byte($urandom_range(0, 1) ? BYTE_PFX_B : BYTE_PFX_T,
                      8'($urandom_range(0, 255)));
        end
        send_byte(pick_command(), 8'($urandom_range(0, 255)));
        count = ($urandom_range(0, 19) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 4);
        send_data(count);
        if (pick < 96) close_frame();
      end
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    wait_drain();
  endtask

  // Receiver: random stalls, one long hold on request
  initial begin : receiver
    int stall;
    out_tready = 1'b0;
    wait (rst_n);
    @(negedge clk);
    forever begin
      if (rx_hold_cycles > 0) begin
        out_tready = 1'b0;
        repeat (rx_hold_cycles) @(negedge clk);
        rx_hold_cycles = 0;
      end
      stall = draw_gap(rx_steady);
      if (stall > 0) begin
        out_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready = 1'b1;
      do @(posedge clk); while (!out_tvalid);
      @(negedge clk);
    end
  end

  // Compare each taken record against the oldest prediction
  always @(posedge clk) begin : scoreboard
    rec_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (records_due.size() == 0) begin
        report_mismatch("unexpected record, record_kind", int'(out_tuser), -1);
      end else begin
        want = records_due.pop_front();
        if (out_tuser != want.rec)
          report_mismatch("record_kind", int'(out_tuser), int'(want.rec));
        if (out_tdata[3:0] != want.kind)
          report_mismatch("command_kind", int'(out_tdata[3:0]), int'(want.kind));
        if (out_tdata[11:4] != want.addr)
          report_mismatch("reg_address", int'(out_tdata[11:4]), int'(want.addr));
        if (out_tdata[19:12] != want.data)
          report_mismatch("data_byte", int'(out_tdata[19:12]), int'(want.data));
        if (out_tdata[30:20] != want.idx)
          report_mismatch("byte_index", int'(out_tdata[30:20]), int'(want.idx));
      end
    end
  end

  // Sequence the tests
  initial begin
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    rst_n     = 1'b0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    test_before_release();
    test_register_access();
    test_special_commands();
    test_prefixes();
    test_backpressure();
    test_excess_bytes();
    test_random_traffic(RANDOM_WORDS);
    wait_drain();
    if (mismatches == 0 && records_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+design
design/nscm_pkg.sv
design/nscm_front.sv
design/nscm_queue.sv
design/nscm_back.sv
design/nfc_spi_command_monitor_core.sv
design/nscm_checker.sv
bench/tb_nfc_spi_command_monitor_core.sv
